// ===== sv/sslp_pkg.sv =====
package sslp_pkg;

  // coefficient formats
  localparam int COEF_W = 16;
  localparam int F_FRAC = 14;
  localparam int Q_FRAC = 15;

  // register file
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_CUTOFF  = 1'b0;
  localparam logic REG_DAMPING = 1'b1;
  localparam logic [COEF_W-1:0] CUTOFF_RESET  = 16'h8000;
  localparam logic [COEF_W-1:0] DAMPING_RESET = 16'h4000;

  // microprogram
  localparam int UC_DEPTH = 7;
  localparam int STEP_W   = 3;

  typedef enum logic {
    COEF_F,
    COEF_Q
  } mul_coef_t;

  typedef enum logic [1:0] {
    OPD_BAND,
    OPD_X,
    OPD_HIGH
  } mul_opd_t;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_LOW,
    ALU_TMP,
    ALU_HIGH,
    ALU_BAND
  } alu_op_t;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_CH_LOOP,
    BR_COMMIT
  } seq_br_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    mul_coef_t coef;
    mul_opd_t  opd;
    logic      mul_en;
    alu_op_t   alu;
    seq_br_t   br;
  } ucode_t;

  typedef struct packed {
    ucode_t uc;
    logic   ch;
    logic   load_x;
    logic   commit;
  } sslp_ctrl_t;

  localparam ucode_t UC_IDLE =
    '{coef: COEF_F, opd: OPD_BAND, mul_en: 1'b0, alu: ALU_NOP, br: BR_NEXT};

  // one channel per pass; the loop step runs the pass again for the right channel
  localparam ucode_t UCODE [UC_DEPTH] = '{
    // f*band
    '{coef: COEF_F, opd: OPD_BAND, mul_en: 1'b1, alu: ALU_NOP,  br: BR_NEXT},
    // low += rnd(f*band); q*x
    '{coef: COEF_Q, opd: OPD_X,    mul_en: 1'b1, alu: ALU_LOW,  br: BR_NEXT},
    // tmp = rnd(q*x) - low; q*band
    '{coef: COEF_Q, opd: OPD_BAND, mul_en: 1'b1, alu: ALU_TMP,  br: BR_NEXT},
    // high = sat(tmp - rnd(q*band))
    '{coef: COEF_F, opd: OPD_HIGH, mul_en: 1'b0, alu: ALU_HIGH, br: BR_NEXT},
    // f*high
    '{coef: COEF_F, opd: OPD_HIGH, mul_en: 1'b1, alu: ALU_NOP,  br: BR_NEXT},
    // band += rnd(f*high); back to top for the right channel
    '{coef: COEF_F, opd: OPD_BAND, mul_en: 1'b0, alu: ALU_BAND, br: BR_CH_LOOP},
    // hand the frame to the output register
    '{coef: COEF_F, opd: OPD_BAND, mul_en: 1'b0, alu: ALU_NOP,  br: BR_COMMIT}
  };

endpackage

// ===== sv/sslp_seq.sv =====
module sslp_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output sslp_pkg::sslp_ctrl_t ctrl
);

  sslp_pkg::seq_state_t        state_r, state_nxt;
  logic [sslp_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        ch_r, ch_nxt;
  logic                        out_valid_r, out_valid_nxt;
  sslp_pkg::ucode_t            uc;
  logic                        slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    uc            = sslp_pkg::UC_IDLE;
    state_nxt     = state_r;
    step_nxt      = step_r;
    ch_nxt        = ch_r;
    ctrl.load_x   = 1'b0;
    ctrl.commit   = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      sslp_pkg::SEQ_IDLE: begin
        if (in_valid) begin
          ctrl.load_x = 1'b1;
          state_nxt   = sslp_pkg::SEQ_RUN;
          step_nxt    = '0;
          ch_nxt      = 1'b0;
        end
      end
      sslp_pkg::SEQ_RUN: begin
        uc = sslp_pkg::UCODE[step_r];
        unique case (uc.br)
          sslp_pkg::BR_NEXT: step_nxt = step_r + 1'b1;
          sslp_pkg::BR_CH_LOOP: begin
            if (!ch_r) begin
              ch_nxt   = 1'b1;
              step_nxt = '0;
            end else begin
              step_nxt = step_r + 1'b1;
            end
          end
          sslp_pkg::BR_COMMIT: begin
            if (slot_free) begin
              ctrl.commit   = 1'b1;
              out_valid_nxt = 1'b1;
              state_nxt     = sslp_pkg::SEQ_IDLE;
            end
          end
          default: step_nxt = '0;
        endcase
      end
      default: state_nxt = sslp_pkg::SEQ_IDLE;
    endcase
    ctrl.uc = uc;
    ctrl.ch = ch_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sslp_pkg::SEQ_IDLE;
      step_r      <= '0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != sslp_pkg::SEQ_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/sslp_dp.sv =====
module sslp_dp #(
  parameter int SAMPLE_BITS = 16,
  parameter int STATE_BITS  = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sslp_pkg::sslp_ctrl_t              ctrl,
  input  logic        [sslp_pkg::COEF_W-1:0] coef_f,
  input  logic        [sslp_pkg::COEF_W-1:0] coef_q,
  input  logic signed [SAMPLE_BITS-1:0]     in_left,
  input  logic signed [SAMPLE_BITS-1:0]     in_right,
  output logic signed [SAMPLE_BITS-1:0]     out_left,
  output logic signed [SAMPLE_BITS-1:0]     out_right
);

  localparam int OPW = (STATE_BITS > SAMPLE_BITS) ? STATE_BITS : SAMPLE_BITS;
  localparam int PW  = OPW + sslp_pkg::COEF_W + 1;
  localparam int AW  = OPW + 4;

  localparam logic signed [AW-1:0] ST_MAX =
    {{(AW-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [AW-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [AW-1:0] SM_MAX =
    {{(AW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [AW-1:0] SM_MIN = ~SM_MAX;
  localparam logic signed [PW-1:0] HALF_F = PW'(1) <<< (sslp_pkg::F_FRAC - 1);
  localparam logic signed [PW-1:0] HALF_Q = PW'(1) <<< (sslp_pkg::Q_FRAC - 1);

  function automatic logic signed [STATE_BITS-1:0] sat_state(input logic signed [AW-1:0] v);
    logic signed [STATE_BITS-1:0] r;
    if (v > ST_MAX)      r = $signed({1'b0, {(STATE_BITS-1){1'b1}}});
    else if (v < ST_MIN) r = $signed({1'b1, {(STATE_BITS-1){1'b0}}});
    else                 r = $signed(v[STATE_BITS-1:0]);
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [STATE_BITS-1:0] s
  );
    logic signed [AW-1:0]          v;
    logic signed [SAMPLE_BITS-1:0] r;
    v = AW'(s);
    if (v > SM_MAX)      r = $signed({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    else if (v < SM_MIN) r = $signed({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    else                 r = $signed(v[SAMPLE_BITS-1:0]);
    return r;
  endfunction

  logic signed [STATE_BITS-1:0]  low_r  [2];
  logic signed [STATE_BITS-1:0]  band_r [2];
  logic signed [SAMPLE_BITS-1:0] x_r    [2];
  logic signed [STATE_BITS-1:0]  high_r;
  logic signed [AW-1:0]          tmp_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r, out_right_r;

  logic signed [sslp_pkg::COEF_W:0] coef_s;
  logic signed [OPW-1:0]            opd_b;
  logic signed [PW-1:0]             prod_nxt;
  logic signed [PW-1:0]             rb_f, rb_q;
  logic signed [AW-1:0]             rnd, low_ext, band_ext, add_a, add_b, add_res;
  logic                             add_sub, use_f;

  // shared multiplier, product registered before the adder
  always_comb begin
    coef_s = (ctrl.uc.coef == sslp_pkg::COEF_F) ? $signed({1'b0, coef_f})
                                                 : $signed({1'b0, coef_q});
    case (ctrl.uc.opd)
      sslp_pkg::OPD_X:    opd_b = OPW'(x_r[ctrl.ch]);
      sslp_pkg::OPD_HIGH: opd_b = OPW'(high_r);
      default:            opd_b = OPW'(band_r[ctrl.ch]);
    endcase
    prod_nxt = PW'(coef_s) * PW'(opd_b);
  end

  // round half up and drop the coefficient fraction, then one add or subtract
  always_comb begin
    use_f    = (ctrl.uc.alu == sslp_pkg::ALU_LOW) || (ctrl.uc.alu == sslp_pkg::ALU_BAND);
    rb_f     = (prod_r + HALF_F) >>> sslp_pkg::F_FRAC;
    rb_q     = (prod_r + HALF_Q) >>> sslp_pkg::Q_FRAC;
    rnd      = use_f ? AW'(rb_f) : AW'(rb_q);
    low_ext  = AW'(low_r[ctrl.ch]);
    band_ext = AW'(band_r[ctrl.ch]);
    add_sub  = 1'b0;
    add_a    = low_ext;
    add_b    = rnd;
    case (ctrl.uc.alu)
      sslp_pkg::ALU_TMP: begin
        add_a   = rnd;
        add_b   = low_ext;
        add_sub = 1'b1;
      end
      sslp_pkg::ALU_HIGH: begin
        add_a   = tmp_r;
        add_b   = rnd;
        add_sub = 1'b1;
      end
      sslp_pkg::ALU_BAND: add_a = band_ext;
      default: ;
    endcase
    add_res = add_sub ? (add_a - add_b) : (add_a + add_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r[0]  <= '0;
      low_r[1]  <= '0;
      band_r[0] <= '0;
      band_r[1] <= '0;
    end else begin
      if (ctrl.uc.alu == sslp_pkg::ALU_LOW)  low_r[ctrl.ch]  <= sat_state(add_res);
      if (ctrl.uc.alu == sslp_pkg::ALU_BAND) band_r[ctrl.ch] <= sat_state(add_res);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_x) begin
      x_r[0] <= in_left;
      x_r[1] <= in_right;
    end
    if (ctrl.uc.mul_en)                    prod_r <= prod_nxt;
    if (ctrl.uc.alu == sslp_pkg::ALU_TMP)  tmp_r  <= add_res;
    if (ctrl.uc.alu == sslp_pkg::ALU_HIGH) high_r <= sat_state(add_res);
    if (ctrl.commit) begin
      out_left_r  <= sat_sample(low_r[0]);
      out_right_r <= sat_sample(low_r[1]);
    end
  end

  assign out_left  = out_left_r;
  assign out_right = out_right_r;

endmodule

// ===== sv/stereo_state_variable_lowpass_top.sv =====
// Stereo two-pole state-variable lowpass. A frame (left and right sample) enters on the
// input channel and the pair of new lowpass samples leaves on the output channel, one
// result beat per input beat, in order. One 17 x 24 multiplier and one adder are shared
// by both channels under a seven-word microprogram: six steps per channel (four
// multiplies, four accumulates) and one step to load the output register. A frame is
// accepted in the idle state and then runs the six steps for each channel and the commit
// step. The commit step holds only while the previous result is still waiting on the
// output (out_stall high), so a new frame is taken while a finished result sits in the
// output register. Coefficients are shared by both channels: register 0 (byte 0x0) is
// the cutoff coefficient f, unsigned Q2.14, reset 0x8000; register 1 (byte 0x4) is the
// damping q, Q1.15, reset 0x4000, which also scales the input. Only the low 16 bits of
// pwdata are kept and no range clamping is done in hardware. Write them only while no
// frame is in flight. Internal state is STATE_BITS wide and saturates; outputs saturate
// to SAMPLE_BITS.
module stereo_state_variable_lowpass_top #(
  parameter int SAMPLE_BITS = 16,
  parameter int STATE_BITS  = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input beat
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0]     in_right_sample,
  // result beat
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     out_left_lowpass,
  output logic signed [SAMPLE_BITS-1:0]     out_right_lowpass,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic        [sslp_pkg::ADDR_W-1:0] paddr,
  input  logic        [sslp_pkg::DATA_W-1:0] pwdata,
  output logic        [sslp_pkg::DATA_W-1:0] prdata,
  output logic                              pready
);

  logic [sslp_pkg::COEF_W-1:0] cutoff_r, cutoff_nxt;
  logic [sslp_pkg::COEF_W-1:0] damping_r, damping_nxt;
  logic                        reg_wr;
  logic                        reg_idx;
  sslp_pkg::sslp_ctrl_t        ctrl;

  // registers are word aligned: the word index is address bit 2
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cutoff_nxt  = cutoff_r;
    damping_nxt = damping_r;
    if (reg_wr) begin
      unique case (reg_idx)
        sslp_pkg::REG_CUTOFF:  cutoff_nxt  = pwdata[sslp_pkg::COEF_W-1:0];
        sslp_pkg::REG_DAMPING: damping_nxt = pwdata[sslp_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      sslp_pkg::REG_CUTOFF:  prdata = sslp_pkg::DATA_W'(cutoff_r);
      sslp_pkg::REG_DAMPING: prdata = sslp_pkg::DATA_W'(damping_r);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r  <= sslp_pkg::CUTOFF_RESET;
      damping_r <= sslp_pkg::DAMPING_RESET;
    end else begin
      cutoff_r  <= cutoff_nxt;
      damping_r <= damping_nxt;
    end
  end

  // step counter, microcode ROM and beat handshakes
  sslp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  // shared multiplier, adder, filter state and output register
  sslp_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STATE_BITS  (STATE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .coef_f    (cutoff_r),
    .coef_q    (damping_r),
    .in_left   (in_left_sample),
    .in_right  (in_right_sample),
    .out_left  (out_left_lowpass),
    .out_right (out_right_lowpass)
  );

  // a taken frame keeps the input stalled until its result is committed
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepting a frame");

  // commit never overwrites a result that is still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.commit |-> (!out_valid || !out_stall))
    else $error("commit over an unread result");

  // every commit raises the result beat
  assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.commit |=> out_valid)
    else $error("commit without result beat");

  // input samples are latched only from the idle state
  assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load_x |-> !in_stall)
    else $error("input latched while busy");

endmodule
